// ===== rtl/stencil_diffusion_cell_update_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the stencil diffusion cell update core
// Concurrent checks clocked by clock and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef STENCIL_DIFFUSION_CELL_UPDATE_CORE_MACROS_SVH
`define STENCIL_DIFFUSION_CELL_UPDATE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SDCU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SDCU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SDCU_ASSERT_SAME(label, ante, cons, msg)
`define SDCU_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/sdcu_pkg.sv =====
// ---------------------------------------------------------------------------
// sdcu_pkg
// Widths, payload types and register indexes of the diffusion cell update.
// ---------------------------------------------------------------------------
`default_nettype none

package sdcu_pkg;

   localparam int VALUE_WIDTH     = 24;
   localparam int GAIN_WIDTH      = 24;
   localparam int OFFSET_WIDTH    = VALUE_WIDTH + 1;
   localparam int DIFF_WIDTH      = VALUE_WIDTH + 1;
   localparam int SUM_WIDTH       = VALUE_WIDTH + 3;
   localparam int PROD_WIDTH      = SUM_WIDTH + GAIN_WIDTH + 1;
   localparam int ACC_WIDTH       = PROD_WIDTH + 1;
   localparam int QUOT_WIDTH      = ACC_WIDTH - GAIN_WIDTH;
   localparam int RES_WIDTH       = QUOT_WIDTH + 1;
   localparam int NEIGHBORS       = 8;
   localparam int SIDES           = 4;
   localparam int USABLE_WIDTH    = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = (OFFSET_WIDTH > GAIN_WIDTH) ? OFFSET_WIDTH : GAIN_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIDE_GAIN     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CORNER_GAIN   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_OFFSET = 2'd2;

   typedef logic        [VALUE_WIDTH-1:0]  value_type;
   typedef logic        [GAIN_WIDTH-1:0]   gain_type;
   typedef logic signed [OFFSET_WIDTH-1:0] offset_type;
   typedef logic signed [DIFF_WIDTH-1:0]   diff_type;
   typedef logic signed [SUM_WIDTH-1:0]    sum_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [ACC_WIDTH-1:0]    acc_type;
   typedef logic signed [RES_WIDTH-1:0]    res_type;

   localparam acc_type ROUND_HALF = acc_type'(1) <<< (GAIN_WIDTH - 1);

   typedef struct packed {
      value_type                center_value;
      value_type                east_value;
      value_type                north_value;
      value_type                west_value;
      value_type                south_value;
      value_type                northeast_value;
      value_type                northwest_value;
      value_type                southwest_value;
      value_type                southeast_value;
      logic [USABLE_WIDTH-1:0]  neighbor_usable;
      logic                     outside_disc;
   } req_payload_type;

   typedef struct packed {
      value_type new_value;
      logic      went_negative;
   } rsp_payload_type;

   // per-stage side information that rides along the datapath
   typedef struct packed {
      logic      outside_disc;
      value_type center_value;
   } ctx_type;

endpackage

`default_nettype wire

// ===== rtl/sdcu_lane.sv =====
// ---------------------------------------------------------------------------
// sdcu_lane
// One neighbor lane: registered masked difference neighbor minus center.
// ---------------------------------------------------------------------------
`default_nettype none

module sdcu_lane (
   input  wire logic               clock,
   input  wire logic               advance,
   input  wire sdcu_pkg::value_type neighbor_value,
   input  wire sdcu_pkg::value_type center_value,
   input  wire logic               usable,
   output sdcu_pkg::diff_type      diff
);
   import sdcu_pkg::*;

   diff_type diff_ff;
   diff_type diff_in;

   always_comb begin
      if (usable) begin
         diff_in = $signed({1'b0, neighbor_value}) - $signed({1'b0, center_value});
      end else begin
         diff_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff <= diff_in;
      end
   end

   assign diff = diff_ff;

endmodule

`default_nettype wire

// ===== rtl/sdcu_merge.sv =====
// ---------------------------------------------------------------------------
// sdcu_merge
// Merge stage: sums side lanes and corner lanes into two registered totals.
// ---------------------------------------------------------------------------
`default_nettype none

module sdcu_merge (
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire sdcu_pkg::diff_type lane_diff [sdcu_pkg::NEIGHBORS],
   output sdcu_pkg::sum_type      side_sum,
   output sdcu_pkg::sum_type      corner_sum
);
   import sdcu_pkg::*;

   sum_type side_sum_ff;
   sum_type side_sum_in;
   sum_type corner_sum_ff;
   sum_type corner_sum_in;

   always_comb begin
      side_sum_in   = '0;
      corner_sum_in = '0;
      for (int i = 0; i < SIDES; i++) begin
         side_sum_in   = side_sum_in + sum_type'(lane_diff[i]);
         corner_sum_in = corner_sum_in + sum_type'(lane_diff[SIDES + i]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_sum_ff   <= side_sum_in;
         corner_sum_ff <= corner_sum_in;
      end
   end

   assign side_sum   = side_sum_ff;
   assign corner_sum = corner_sum_ff;

endmodule

`default_nettype wire

// ===== rtl/sdcu_update.sv =====
// ---------------------------------------------------------------------------
// sdcu_update
// Gain multiply, single rounding, offset, center add, clamp and saturate; zero outside the disc.
// ---------------------------------------------------------------------------
`default_nettype none

module sdcu_update (
   input  wire logic                   clock,
   input  wire logic                   advance,
   input  wire sdcu_pkg::sum_type      side_sum,
   input  wire sdcu_pkg::sum_type      corner_sum,
   input  wire sdcu_pkg::gain_type     side_gain,
   input  wire sdcu_pkg::gain_type     corner_gain,
   input  wire sdcu_pkg::offset_type   target_offset,
   input  wire sdcu_pkg::ctx_type      ctx,
   output sdcu_pkg::rsp_payload_type   result
);
   import sdcu_pkg::*;

   prod_type        prod_side_ff;
   prod_type        prod_side_in;
   prod_type        prod_corner_ff;
   prod_type        prod_corner_in;
   acc_type         acc;
   res_type         raw;
   rsp_payload_type result_ff;
   rsp_payload_type result_in;

   // gains are unsigned: widen with a zero sign bit
   assign prod_side_in   = prod_type'(side_sum) * prod_type'($signed({1'b0, side_gain}));
   assign prod_corner_in = prod_type'(corner_sum) * prod_type'($signed({1'b0, corner_gain}));

   always_comb begin
      acc = acc_type'(prod_side_ff) + acc_type'(prod_corner_ff) + ROUND_HALF;
      raw = res_type'($signed(acc[ACC_WIDTH-1:GAIN_WIDTH]))
          + res_type'($signed({1'b0, ctx.center_value}))
          - res_type'(target_offset);
      result_in = '0;
      if (ctx.outside_disc) begin
         result_in = '0;
      end else if (raw[RES_WIDTH-1]) begin
         result_in.went_negative = 1'b1;
      end else if (raw[RES_WIDTH-2:VALUE_WIDTH] != '0) begin
         result_in.new_value = '1;
      end else begin
         result_in.new_value = raw[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_side_ff   <= prod_side_in;
         prod_corner_ff <= prod_corner_in;
         result_ff      <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/stencil_diffusion_cell_update_core.sv =====
// ---------------------------------------------------------------------------
// stencil_diffusion_cell_update_core
// Nine-point explicit diffusion update of one cell per transaction.
// ---------------------------------------------------------------------------
//   channel   direction   handshake           payload
//   req_*     in          valid / stall       req_payload_type (3x3 window)
//   rsp_*     out         valid / stall       rsp_payload_type (new value, flag)
//   csr_*     in          write enable only   index + data, no read-back
//
// One transaction per cycle while no held result is stalled; the registered
// stages are lanes, merge, multiply, and round and clamp. The whole pipeline
// advances together; rsp_stall with a held result freezes it and raises
// req_stall in the same cycle. Reset clears the valid bits and the gain and
// offset registers; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module stencil_diffusion_cell_update_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire sdcu_pkg::req_payload_type            req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output sdcu_pkg::rsp_payload_type                 rsp_payload,
   input  wire logic                                 csr_write_en,
   input  wire logic [sdcu_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [sdcu_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import sdcu_pkg::*;

   `include "stencil_diffusion_cell_update_core_macros.svh"

   gain_type   side_gain_ff;
   gain_type   corner_gain_ff;
   offset_type target_offset_ff;

   logic       advance;
   logic       valid1_ff;
   logic       valid2_ff;
   logic       valid3_ff;
   logic       rsp_valid_ff;
   ctx_type    ctx1_ff;
   ctx_type    ctx2_ff;
   ctx_type    ctx3_ff;
   ctx_type    ctx0;

   value_type  neighbor [NEIGHBORS];
   diff_type   lane_diff [NEIGHBORS];
   sum_type    side_sum;
   sum_type    corner_sum;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;

   // lane order follows the usable mask: E N W S NE NW SW SE
   assign neighbor[0] = req_payload.east_value;
   assign neighbor[1] = req_payload.north_value;
   assign neighbor[2] = req_payload.west_value;
   assign neighbor[3] = req_payload.south_value;
   assign neighbor[4] = req_payload.northeast_value;
   assign neighbor[5] = req_payload.northwest_value;
   assign neighbor[6] = req_payload.southwest_value;
   assign neighbor[7] = req_payload.southeast_value;

   assign ctx0.outside_disc = req_payload.outside_disc;
   assign ctx0.center_value = req_payload.center_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_gain_ff     <= '0;
         corner_gain_ff   <= '0;
         target_offset_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SIDE_GAIN:     side_gain_ff     <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_CORNER_GAIN:   corner_gain_ff   <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_TARGET_OFFSET: target_offset_ff <= $signed(csr_wdata[OFFSET_WIDTH-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         valid3_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff    <= req_valid;
         valid2_ff    <= valid1_ff;
         valid3_ff    <= valid2_ff;
         rsp_valid_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctx1_ff <= ctx0;
         ctx2_ff <= ctx1_ff;
         ctx3_ff <= ctx2_ff;
      end
   end

   for (genvar g = 0; g < NEIGHBORS; g++) begin : g_lane
      sdcu_lane u_lane (
         .clock          (clock),
         .advance        (advance),
         .neighbor_value (neighbor[g]),
         .center_value   (req_payload.center_value),
         .usable         (req_payload.neighbor_usable[g]),
         .diff           (lane_diff[g])
      );
   end

   sdcu_merge u_merge (
      .clock      (clock),
      .advance    (advance),
      .lane_diff  (lane_diff),
      .side_sum   (side_sum),
      .corner_sum (corner_sum)
   );

   // the products sit in stage three, so the final stage takes stage three side data
   sdcu_update u_update (
      .clock         (clock),
      .advance       (advance),
      .side_sum      (side_sum),
      .corner_sum    (corner_sum),
      .side_gain     (side_gain_ff),
      .corner_gain   (corner_gain_ff),
      .target_offset (target_offset_ff),
      .ctx           (ctx3_ff),
      .result        (rsp_payload)
   );

   `SDCU_ASSERT_SAME(a_neg_is_zero, rsp_valid && rsp_payload.went_negative,
      rsp_payload.new_value == '0, "clamped result is not zero")
   `SDCU_ASSERT_NEXT(a_outside_zero, advance && valid3_ff && ctx3_ff.outside_disc,
      rsp_payload == '0, "outside-disc cell gave a nonzero result")
   `SDCU_ASSERT_NEXT(a_stall_freezes, !advance,
      $stable(valid3_ff) && $stable(ctx3_ff), "pipeline moved while stalled")
   `SDCU_ASSERT_NEXT(a_side_gain_write, csr_write_en && csr_index == CSR_SIDE_GAIN,
      side_gain_ff == $past(csr_wdata[GAIN_WIDTH-1:0]), "side gain write lost")

endmodule

`default_nettype wire
